[rtl/assert_macros.svh]
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define KM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds through reset
`define KM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/km2d_pkg.sv]
// shared types and constants of the 2d k-means block
`default_nettype none
package km2d_pkg;

  localparam int CW        = 16;          // coordinate width
  localparam int NK        = 8;           // centroid cells
  localparam int KW        = 3;           // centroid index width
  localparam int CLW       = 4;           // cluster mark width
  localparam int IDXW      = 10;          // index field width
  localparam int DISTW     = 2 * CW + 3;  // squared distance width
  localparam int DRAIN_CYC = 2 * NK + 4;  // chain latency plus margin
  localparam int DRW       = 5;
  localparam logic [CLW-1:0] UNASSIGNED = 4'd8;

  typedef enum logic [2:0] {
    OP_LOAD_POINT = 3'd0,
    OP_SET_CENT   = 3'd1,
    OP_RUN        = 3'd2,
    OP_READ_CLUS  = 3'd3,
    OP_READ_CENT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_NUM_CLUSTERS = 2'd0,
    REG_MAX_ITER     = 2'd1,
    REG_POINT_COUNT  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PASS, S_FEED, S_DRAIN, S_MOVE, S_DIVX, S_DIVY, S_NEXT
  } state_t;

  // point traveling down the centroid chain
  typedef struct packed {
    logic                  valid;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic [CLW-1:0]        mark;
    logic [IDXW-1:0]       pidx;
    logic [DISTW-1:0]      best_d;
    logic [KW-1:0]         best;
  } token_t;

  // control broadcast to all cells
  typedef struct packed {
    logic          clear;
    logic          acc_en;
    logic [KW-1:0] acc_sel;
    logic          wr_en;
    logic [KW-1:0] wr_sel;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/km2d_ram.sv]
// generic single write, single registered read memory
`default_nettype none
module km2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/km2d_cell.sv]
// one centroid cell: distance compare stage pair plus member accumulators
`default_nettype none
module km2d_cell import km2d_pkg::*; #(
  parameter int CELL_ID = 0,
  parameter int SUMW    = 27,
  parameter int CNTW    = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   active,
  input  cell_ctrl_t             ctrl,
  input  logic signed [CW-1:0]   wr_x,
  input  logic signed [CW-1:0]   wr_y,
  input  logic signed [CW-1:0]   acc_x,
  input  logic signed [CW-1:0]   acc_y,
  input  token_t                 tok_in,
  output token_t                 tok_out,
  output logic signed [CW-1:0]   cent_x,
  output logic signed [CW-1:0]   cent_y,
  output logic signed [SUMW-1:0] sum_x,
  output logic signed [SUMW-1:0] sum_y,
  output logic [CNTW-1:0]        count
);

  localparam logic [KW-1:0] ID = KW'(CELL_ID);

  logic signed [CW:0]       dx, dy;
  logic signed [2*CW+1:0]   px, py;
  logic [2*CW+1:0]          sqx, sqy;
  token_t                   tok_a;
  logic [DISTW-1:0]         dsum;
  logic                     take;

  // stage a: squared differences
  assign dx = {tok_in.x[CW-1], tok_in.x} - {cent_x[CW-1], cent_x};
  assign dy = {tok_in.y[CW-1], tok_in.y} - {cent_y[CW-1], cent_y};
  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_a.valid <= 1'b0;
    end else begin
      tok_a <= tok_in;
      sqx   <= $unsigned(px);
      sqy   <= $unsigned(py);
    end
  end

  // stage b: sum and compare against best so far
  assign dsum = {1'b0, sqx} + {1'b0, sqy};
  assign take = active && ((CELL_ID == 0) || (dsum < tok_a.best_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_a;
      if (take) begin
        tok_out.best_d <= dsum;
        tok_out.best   <= ID;
      end
    end
  end

  // centroid register
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ctrl.wr_sel == ID) begin
      cent_x <= wr_x;
      cent_y <= wr_y;
    end
  end

  // member sums and count
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum_x <= '0;
      sum_y <= '0;
      count <= '0;
    end else if (ctrl.acc_en && ctrl.acc_sel == ID) begin
      sum_x <= sum_x + {{(SUMW-CW){acc_x[CW-1]}}, acc_x};
      sum_y <= sum_y + {{(SUMW-CW){acc_y[CW-1]}}, acc_y};
      count <= count + CNTW'(1);
    end
  end

endmodule
`default_nettype wire

[rtl/km2d_div.sv]
// signed by unsigned restoring divider, one quotient bit a cycle
`default_nettype none
module km2d_div #(
  parameter int NW  = 27,
  parameter int DVW = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DVW-1:0]       den,
  output logic                 done,
  output logic signed [NW-1:0] quot
);

  localparam int CTW = $clog2(NW + 1);

  logic            busy, neg;
  logic [CTW-1:0]  cnt;
  logic [NW-1:0]   a, a_next;
  logic [DVW-1:0]  rem, rem_next;
  logic [DVW:0]    rs;
  logic            fit;

  // one restoring step
  assign rs       = {rem, a[NW-1]};
  assign fit      = rs >= {1'b0, den};
  assign rem_next = fit ? DVW'(rs - {1'b0, den}) : rs[DVW-1:0];
  assign a_next   = {a[NW-2:0], fit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= num[NW-1];
        a    <= num[NW-1] ? $unsigned(-num) : $unsigned(num);
        rem  <= '0;
        cnt  <= CTW'(NW);
      end else if (busy) begin
        a   <= a_next;
        rem <= rem_next;
        cnt <= cnt - CTW'(1);
        if (cnt == CTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= neg ? -$signed(a_next) : $signed(a_next);
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/kmeans_2d_clustering.sv]
// top level of the 2d k-means block
// Usage: an item is taken when start is high and busy is low. Opcode 0 loads
// a point, 1 sets a starting centroid, 2 runs Lloyd iterations, 3 reads a
// point's cluster, 4 reads a centroid. The result shows on status, cluster,
// iterations, result_x and result_y for one cycle with done high; the
// receiver cannot stall it. Loads, centroid writes and reads give done in the
// cycle after the item is taken, then the block is ready again at once.
// During a run busy stays high: each pass streams the points one a cycle
// through a chain of NK centroid cells (two stages each), then a shared
// serial divider computes each new mean coordinate in turn.
// Configuration writes (cfg_index 0 clusters, 1 iteration limit, 2 point
// count) are always ready; the user must make them only while the block is
// idle, and the block itself does not enforce this.
// After reset the block sweeps the cluster marks to unassigned, one entry a
// cycle, and busy stays high until the sweep is through.
`default_nettype none
module kmeans_2d_clustering import km2d_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           opcode,
  input  logic [IDXW-1:0]      index,
  input  logic signed [CW-1:0] coord_x,
  input  logic signed [CW-1:0] coord_y,
  output logic                 done,
  output logic                 status,
  output logic [CLW-1:0]       cluster,
  output logic [9:0]           iterations,
  output logic signed [CW-1:0] result_x,
  output logic signed [CW-1:0] result_y,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data
);

  localparam int PAW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SUMW = CW + PAW + 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);

  state_t state, state_next;

  logic [3:0]  num_clusters;
  logic [9:0]  max_iterations;
  logic [10:0] point_count;

  logic [PAW-1:0] clr_addr, feed_addr, rd_addr_q;
  logic           rd_v;
  logic [KW-1:0]  j_sel;
  logic [DRW-1:0] drain_cnt;
  logic [9:0]     iter;
  logic           changed;
  logic signed [CW-1:0] qx;
  logic           rdc_q;

  logic signed [CW-1:0] x_rdata, y_rdata;
  logic [CLW-1:0]       c_rdata;
  logic                 p_we, c_we;
  logic [PAW-1:0]       c_waddr, p_raddr;
  logic [CLW-1:0]       c_wdata;

  token_t     tok [NK+1];
  cell_ctrl_t ctrl;
  logic signed [CW-1:0]   wr_x, wr_y;
  logic signed [CW-1:0]   cent_x [NK];
  logic signed [CW-1:0]   cent_y [NK];
  logic signed [SUMW-1:0] sum_x [NK];
  logic signed [SUMW-1:0] sum_y [NK];
  logic [CNTW-1:0]        count [NK];

  logic                   div_start, div_done;
  logic signed [SUMW-1:0] div_num, div_quot;

  logic                   accept, pt_ok, cent_ok, run_bad, last_feed, last_j;
  logic [9:0]             iter_inc;
  logic                   res_en, res_status, res_rdc;
  logic [9:0]             res_iter;
  logic signed [CW-1:0]   res_x, res_y;
  token_t                 tend;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign pt_ok     = 32'(index) < MAX_POINTS;
  assign cent_ok   = index[IDXW-1:KW] == '0;
  assign run_bad   = (point_count == '0) || (32'(point_count) > MAX_POINTS) ||
                     (num_clusters == '0) || (num_clusters > 4'(NK));
  assign last_feed = 32'(feed_addr) == 32'(point_count) - 1;
  assign last_j    = ({1'b0, j_sel} + 4'd1) == num_clusters;
  assign iter_inc  = iter + 10'd1;
  assign tend      = tok[NK];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters   <= 4'd5;
      max_iterations <= 10'd100;
      point_count    <= 11'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_NUM_CLUSTERS: num_clusters   <= cfg_data[3:0];
        REG_MAX_ITER:     max_iterations <= cfg_data[9:0];
        REG_POINT_COUNT:  point_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  // point memories
  km2d_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(p_we), .waddr(index[PAW-1:0]), .wdata(coord_x),
    .raddr(feed_addr), .rdata(x_rdata)
  );
  km2d_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(p_we), .waddr(index[PAW-1:0]), .wdata(coord_y),
    .raddr(feed_addr), .rdata(y_rdata)
  );
  km2d_ram #(.WIDTH(CLW), .DEPTH(MAX_POINTS)) u_ram_c (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(p_raddr), .rdata(c_rdata)
  );

  assign p_raddr = (state == S_FEED) ? feed_addr : index[PAW-1:0];

  // token entering the chain from the memory read
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = rd_v;
    tok[0].x      = x_rdata;
    tok[0].y      = y_rdata;
    tok[0].mark   = c_rdata;
    tok[0].pidx   = IDXW'(rd_addr_q);
  end

  // centroid cell chain
  for (genvar j = 0; j < NK; j++) begin : g_cell
    km2d_cell #(.CELL_ID(j), .SUMW(SUMW), .CNTW(CNTW)) u_cell (
      .clk(clk), .rst(rst), .active(4'(j) < num_clusters), .ctrl(ctrl),
      .wr_x(wr_x), .wr_y(wr_y), .acc_x(tend.x), .acc_y(tend.y),
      .tok_in(tok[j]), .tok_out(tok[j+1]),
      .cent_x(cent_x[j]), .cent_y(cent_y[j]),
      .sum_x(sum_x[j]), .sum_y(sum_y[j]), .count(count[j])
    );
  end

  // shared mean divider
  assign div_num = (state == S_DIVX) ? sum_y[j_sel] : sum_x[j_sel];

  km2d_div #(.NW(SUMW), .DVW(CNTW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(count[j_sel]), .done(div_done), .quot(div_quot)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next   = state;
    p_we         = 1'b0;
    c_we         = 1'b0;
    c_waddr      = clr_addr;
    c_wdata      = UNASSIGNED;
    ctrl         = '0;
    ctrl.acc_en  = tend.valid;
    ctrl.acc_sel = tend.best;
    ctrl.wr_sel  = j_sel;
    wr_x         = qx;
    wr_y         = div_quot[CW-1:0];
    div_start    = 1'b0;
    res_en       = 1'b0;
    res_status   = 1'b0;
    res_rdc      = 1'b0;
    res_iter     = '0;
    res_x        = '0;
    res_y        = '0;
    // mark writeback at the chain end
    if (tend.valid && tend.mark != CLW'(tend.best)) begin
      c_we    = 1'b1;
      c_waddr = tend.pidx[PAW-1:0];
      c_wdata = CLW'(tend.best);
    end
    case (state)
      S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_addr;
        c_wdata = UNASSIGNED;
        if (32'(clr_addr) == MAX_POINTS - 1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          res_en = 1'b1;
          case (opcode)
            OP_LOAD_POINT: begin
              res_status = !pt_ok;
              p_we       = pt_ok;
              c_we       = pt_ok;
              c_waddr    = index[PAW-1:0];
              c_wdata    = UNASSIGNED;
            end
            OP_SET_CENT: begin
              res_status  = !cent_ok;
              ctrl.wr_en  = cent_ok;
              ctrl.wr_sel = index[KW-1:0];
              wr_x        = coord_x;
              wr_y        = coord_y;
            end
            OP_RUN: begin
              if (run_bad) begin
                res_status = 1'b1;
              end else if (max_iterations != '0) begin
                res_en     = 1'b0;
                state_next = S_PASS;
              end
            end
            OP_READ_CLUS: begin
              res_status = !pt_ok;
              res_rdc    = pt_ok;
            end
            OP_READ_CENT: begin
              res_status = !cent_ok;
              if (cent_ok) begin
                res_x = cent_x[index[KW-1:0]];
                res_y = cent_y[index[KW-1:0]];
              end
            end
            default: res_status = 1'b1;
          endcase
        end
      end
      S_PASS: begin
        ctrl.clear = 1'b1;
        state_next = S_FEED;
      end
      S_FEED: begin
        if (last_feed) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain_cnt == DRW'(DRAIN_CYC - 1)) begin
          if (!changed) begin
            res_en     = 1'b1;
            res_iter   = iter_inc;
            state_next = S_IDLE;
          end else begin
            state_next = S_MOVE;
          end
        end
      end
      S_MOVE: begin
        if (count[j_sel] == '0) begin
          state_next = S_NEXT;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          ctrl.wr_en = 1'b1;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!last_j) begin
          state_next = S_MOVE;
        end else if (iter == max_iterations) begin
          res_en     = 1'b1;
          res_iter   = iter;
          state_next = S_IDLE;
        end else begin
          state_next = S_PASS;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // run counters and stream control
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      rd_v     <= 1'b0;
    end else begin
      rd_v      <= (state == S_FEED);
      rd_addr_q <= feed_addr;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + PAW'(1);
        S_IDLE:  iter <= '0;
        S_PASS: begin
          feed_addr <= '0;
          changed   <= 1'b0;
          drain_cnt <= '0;
        end
        S_FEED: begin
          if (!last_feed) feed_addr <= feed_addr + PAW'(1);
        end
        S_DRAIN: begin
          drain_cnt <= drain_cnt + DRW'(1);
          j_sel     <= '0;
          if (drain_cnt == DRW'(DRAIN_CYC - 1)) iter <= iter_inc;
        end
        S_DIVX: if (div_done) qx <= div_quot[CW-1:0];
        S_NEXT: j_sel <= j_sel + KW'(1);
        default: ;
      endcase
      if (tend.valid && tend.mark != CLW'(tend.best)) changed <= 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_en;
    end
    if (res_en) begin
      status     <= res_status;
      rdc_q      <= res_rdc;
      iterations <= res_iter;
      result_x   <= res_x;
      result_y   <= res_y;
    end
  end

  assign cluster = rdc_q ? c_rdata : '0;

endmodule
`default_nettype wire

[rtl/km2d_checker.sv]
// port level checks for the 2d k-means block, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module km2d_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [3:0] cluster
);

  // a result never shows while the block is still working
  `KM_ASSERT(a_done_idle, clk, rst, done |-> !busy, "done while busy")
  // an accepted item either answers next cycle or starts a run
  `KM_ASSERT(a_accept_resp, clk, rst, (start && !busy) |=> (done || busy), "item dropped")
  // cluster marks stay within the unassigned code
  `KM_ASSERT(a_cluster_range, clk, rst, done |-> (cluster <= 4'd8), "cluster out of range")
  // reset flushes any pending result
  `KM_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !done, "done after reset")

endmodule

bind kmeans_2d_clustering km2d_checker u_km2d_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .cluster(cluster)
);
`default_nettype wire
